FILE: design/gdhc_pkg.sv
// ----------------------------------------------------------------------------
// gdhc_pkg: shared types and constants of the date / hour count unit
// Field widths, calendar constants, microcode word layout and step labels.
// ----------------------------------------------------------------------------
package gdhc_pkg;

   // field widths
   localparam int COUNT_W = 25;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MH_W    = 10;   // hours in one month, 744 at most

   localparam int DEF_MAX_YEAR = 2500;

   localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
   localparam logic [13:0] YEAR_HOURS      = 14'd8760;
   localparam logic [13:0] LEAP_YEAR_HOURS = 14'd8784;
   localparam logic [MONTH_W-1:0] MONTHS   = 4'd12;
   localparam logic [HOUR_W-1:0]  LAST_HOUR = 5'd23;

   // step counter
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [PC_W-1:0] STEP_DISPATCH  = 4'd1;
   localparam logic [PC_W-1:0] STEP_F_CHECK   = 4'd2;
   localparam logic [PC_W-1:0] STEP_F_YEARS   = 4'd3;
   localparam logic [PC_W-1:0] STEP_F_MONTHS  = 4'd4;
   localparam logic [PC_W-1:0] STEP_F_DAY     = 4'd5;
   localparam logic [PC_W-1:0] STEP_F_FINISH  = 4'd6;
   localparam logic [PC_W-1:0] STEP_R_CHECK   = 4'd7;
   localparam logic [PC_W-1:0] STEP_R_YEARS   = 4'd8;
   localparam logic [PC_W-1:0] STEP_R_MONTHS  = 4'd9;
   localparam logic [PC_W-1:0] STEP_R_DAYS    = 4'd10;
   localparam logic [PC_W-1:0] STEP_EMIT      = 4'd11;

   typedef enum logic [3:0] {
      COND_ALWAYS   = 4'd0,
      COND_REQ      = 4'd1,
      COND_REV      = 4'd2,
      COND_FWD_BAD  = 4'd3,
      COND_Y_LT     = 4'd4,
      COND_M_LT     = 4'd5,
      COND_DAY_BAD  = 4'd6,
      COND_CNT_BAD  = 4'd7,
      COND_T_GE_Y   = 4'd8,
      COND_T_GE_M   = 4'd9,
      COND_T_GE_D   = 4'd10,
      COND_OUT_FREE = 4'd11
   } cond_type;

   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_LOAD      = 4'd1,
      OP_SET_BAD   = 4'd2,
      OP_YEAR_ADD  = 4'd3,
      OP_MONTH_ADD = 4'd4,
      OP_FWD_FIN   = 4'd5,
      OP_YEAR_SUB  = 4'd6,
      OP_MONTH_SUB = 4'd7,
      OP_DAY_SUB   = 4'd8,
      OP_EMIT      = 4'd9
   } op_type;

   // cond true: run op, go to target; cond false: hold or fall through
   typedef struct packed {
      cond_type        cond;
      op_type          op;
      logic [PC_W-1:0] target;
      logic            hold;
   } uword_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] d;
      case (m)
         4'd2:                      d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

   function automatic logic [MH_W-1:0] month_hours(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [MH_W-1:0] d;
      d = MH_W'(month_days(m, leap));
      return (d << 4) + (d << 3);
   endfunction

endpackage

FILE: design/gdhc_urom.sv
// ----------------------------------------------------------------------------
// gdhc_urom: microcode store of the date / hour count sequencer
// One control word per step: condition, datapath operation, jump target, hold bit.
// ----------------------------------------------------------------------------
module gdhc_urom (
   input  logic [gdhc_pkg::PC_W-1:0] step,
   output gdhc_pkg::uword_type       uword
);

   always_comb begin
      case (step)
         gdhc_pkg::STEP_IDLE:
            uword = '{gdhc_pkg::COND_REQ,      gdhc_pkg::OP_LOAD,
                      gdhc_pkg::STEP_DISPATCH, 1'b1};
         gdhc_pkg::STEP_DISPATCH:
            uword = '{gdhc_pkg::COND_REV,      gdhc_pkg::OP_NONE,
                      gdhc_pkg::STEP_R_CHECK,  1'b0};
         gdhc_pkg::STEP_F_CHECK:
            uword = '{gdhc_pkg::COND_FWD_BAD,  gdhc_pkg::OP_SET_BAD,
                      gdhc_pkg::STEP_EMIT,     1'b0};
         gdhc_pkg::STEP_F_YEARS:
            uword = '{gdhc_pkg::COND_Y_LT,     gdhc_pkg::OP_YEAR_ADD,
                      gdhc_pkg::STEP_F_YEARS,  1'b0};
         gdhc_pkg::STEP_F_MONTHS:
            uword = '{gdhc_pkg::COND_M_LT,     gdhc_pkg::OP_MONTH_ADD,
                      gdhc_pkg::STEP_F_MONTHS, 1'b0};
         gdhc_pkg::STEP_F_DAY:
            uword = '{gdhc_pkg::COND_DAY_BAD,  gdhc_pkg::OP_SET_BAD,
                      gdhc_pkg::STEP_EMIT,     1'b0};
         gdhc_pkg::STEP_F_FINISH:
            uword = '{gdhc_pkg::COND_ALWAYS,   gdhc_pkg::OP_FWD_FIN,
                      gdhc_pkg::STEP_EMIT,     1'b0};
         gdhc_pkg::STEP_R_CHECK:
            uword = '{gdhc_pkg::COND_CNT_BAD,  gdhc_pkg::OP_SET_BAD,
                      gdhc_pkg::STEP_EMIT,     1'b0};
         gdhc_pkg::STEP_R_YEARS:
            uword = '{gdhc_pkg::COND_T_GE_Y,   gdhc_pkg::OP_YEAR_SUB,
                      gdhc_pkg::STEP_R_YEARS,  1'b0};
         gdhc_pkg::STEP_R_MONTHS:
            uword = '{gdhc_pkg::COND_T_GE_M,   gdhc_pkg::OP_MONTH_SUB,
                      gdhc_pkg::STEP_R_MONTHS, 1'b0};
         gdhc_pkg::STEP_R_DAYS:
            uword = '{gdhc_pkg::COND_T_GE_D,   gdhc_pkg::OP_DAY_SUB,
                      gdhc_pkg::STEP_R_DAYS,   1'b0};
         gdhc_pkg::STEP_EMIT:
            uword = '{gdhc_pkg::COND_OUT_FREE, gdhc_pkg::OP_EMIT,
                      gdhc_pkg::STEP_IDLE,     1'b1};
         default:
            uword = '{gdhc_pkg::COND_ALWAYS,   gdhc_pkg::OP_NONE,
                      gdhc_pkg::STEP_IDLE,     1'b0};
      endcase
   end

endmodule

FILE: design/gregorian_date_hour_count_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_hour_count_unit: proleptic Gregorian date <-> hour count
// Microcoded converter between year/month/day/hour and hours since
// 0001-01-01 00:00, with range checking.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  operation, year, month, day,
//                                             hour, total_hours
//   rsp       out        rsp_valid/rsp_stall  count_out, year_out, month_out,
//                                             day_out, hour_out, valid_res
//
// Steps: one step a cycle, save where the idle and emit steps hold. Date to
//   count walks the years, then the months, then adds day and hour; count to
//   date walks the years, months and days. The year walk takes longest. A new
//   request is taken only once the sequencer is back at its idle step.
// Reset: synchronous, clears the step counter and the result valid flag.
// Stalls: a finished result sits in the output register; the sequencer
//   waits at its emit step only while that register is still held.
// ----------------------------------------------------------------------------
module gregorian_date_hour_count_unit #(
   parameter int MAX_YEAR = gdhc_pkg::DEF_MAX_YEAR
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [gdhc_pkg::YEAR_W-1:0]    req_year,
   input  logic [gdhc_pkg::MONTH_W-1:0]   req_month,
   input  logic [gdhc_pkg::DAY_W-1:0]     req_day,
   input  logic [gdhc_pkg::HOUR_W-1:0]    req_hour,
   input  logic [gdhc_pkg::COUNT_W-1:0]   req_total_hours,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gdhc_pkg::COUNT_W-1:0]   rsp_count_out,
   output logic [gdhc_pkg::YEAR_W-1:0]    rsp_year_out,
   output logic [gdhc_pkg::MONTH_W-1:0]   rsp_month_out,
   output logic [gdhc_pkg::DAY_W-1:0]     rsp_day_out,
   output logic [gdhc_pkg::HOUR_W-1:0]    rsp_hour_out,
   output logic                           rsp_valid_res
);

   // year counter wide enough for MAX_YEAR + 1 and for the input field
   localparam int YW_MIN = $clog2(MAX_YEAR + 2);
   localparam int YW = (YW_MIN > gdhc_pkg::YEAR_W) ? YW_MIN : gdhc_pkg::YEAR_W;
   // hours in years 1 .. MAX_YEAR
   localparam int LIMIT =
      (MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400) * 24;
   localparam int AW_MIN = $clog2(LIMIT + 1);
   localparam int AW = (AW_MIN > gdhc_pkg::COUNT_W) ? AW_MIN : gdhc_pkg::COUNT_W;

   localparam int CW = gdhc_pkg::COUNT_W;
   localparam int HW = gdhc_pkg::HOUR_W;

   // sequencer
   logic [gdhc_pkg::PC_W-1:0] pc_ff, pc_in;
   gdhc_pkg::uword_type       uword;
   logic                      cond_true;

   // captured request
   logic                           op_ff;
   logic [gdhc_pkg::YEAR_W-1:0]    year_ff;
   logic [gdhc_pkg::MONTH_W-1:0]   month_ff;
   logic [gdhc_pkg::DAY_W-1:0]     day_ff;
   logic [gdhc_pkg::HOUR_W-1:0]    hour_ff;
   logic [CW-1:0]                  total_ff;

   // datapath: acc is the running sum (forward) or the remainder (reverse)
   logic [AW-1:0]                  acc_ff, acc_in;
   logic [YW-1:0]                  y_ff, y_in;
   logic [gdhc_pkg::MONTH_W-1:0]   m_ff, m_in;
   logic [gdhc_pkg::DAY_W-1:0]     d_ff, d_in;
   logic [1:0]                     c4_ff, c4_in;       // y mod 4
   logic [6:0]                     c100_ff, c100_in;   // y mod 100
   logic [8:0]                     c400_ff, c400_in;   // y mod 400
   logic                           bad_ff, bad_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                  count_out_ff;
   logic [gdhc_pkg::YEAR_W-1:0]    year_out_ff;
   logic [gdhc_pkg::MONTH_W-1:0]   month_out_ff;
   logic [gdhc_pkg::DAY_W-1:0]     day_out_ff;
   logic [gdhc_pkg::HOUR_W-1:0]    hour_out_ff;
   logic                           valid_res_ff;

   logic                           leap;
   logic [AW-1:0]                  year_hrs;
   logic [AW-1:0]                  month_hrs;
   logic [AW-1:0]                  day_hrs;
   logic                           run;
   logic                           req_xfer;
   logic                           rsp_xfer;

   gdhc_urom u_urom (
      .step  (pc_ff),
      .uword (uword)
   );

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign req_stall = (pc_ff != gdhc_pkg::STEP_IDLE);

   assign leap = (c4_ff == 2'd0) && ((c100_ff != 7'd0) || (c400_ff == 9'd0));
   assign year_hrs  = leap ? AW'(gdhc_pkg::LEAP_YEAR_HOURS) : AW'(gdhc_pkg::YEAR_HOURS);
   assign month_hrs = AW'(gdhc_pkg::month_hours(m_ff, leap));
   // (day - 1) * 24 + hour
   assign day_hrs = (AW'(day_ff - 5'd1) << 4) + (AW'(day_ff - 5'd1) << 3) + AW'(hour_ff);

   // condition select
   always_comb begin
      case (uword.cond)
         gdhc_pkg::COND_ALWAYS:   cond_true = 1'b1;
         gdhc_pkg::COND_REQ:      cond_true = req_valid;
         gdhc_pkg::COND_REV:      cond_true = op_ff;
         gdhc_pkg::COND_FWD_BAD:  cond_true = (year_ff == '0)
                                     || (YW'(year_ff) > YW'(MAX_YEAR))
                                     || (month_ff == '0)
                                     || (month_ff > gdhc_pkg::MONTHS)
                                     || (day_ff == '0)
                                     || (hour_ff > gdhc_pkg::LAST_HOUR);
         gdhc_pkg::COND_Y_LT:     cond_true = y_ff < YW'(year_ff);
         gdhc_pkg::COND_M_LT:     cond_true = m_ff < month_ff;
         gdhc_pkg::COND_DAY_BAD:  cond_true = day_ff > gdhc_pkg::month_days(month_ff, leap);
         gdhc_pkg::COND_CNT_BAD:  cond_true = acc_ff >= AW'(LIMIT);
         gdhc_pkg::COND_T_GE_Y:   cond_true = acc_ff >= year_hrs;
         gdhc_pkg::COND_T_GE_M:   cond_true = (acc_ff >= month_hrs)
                                     && (m_ff < gdhc_pkg::MONTHS);
         gdhc_pkg::COND_T_GE_D:   cond_true = acc_ff >= AW'(gdhc_pkg::HOURS_PER_DAY);
         gdhc_pkg::COND_OUT_FREE: cond_true = !rsp_valid_ff || !rsp_stall;
         default:                 cond_true = 1'b0;
      endcase
   end

   assign run = cond_true;

   // step counter
   always_comb begin
      if (run) begin
         pc_in = uword.target;
      end else if (uword.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   // datapath operations
   always_comb begin
      acc_in  = acc_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      d_in    = d_ff;
      c4_in   = c4_ff;
      c100_in = c100_ff;
      c400_in = c400_ff;
      bad_in  = bad_ff;
      if (run) begin
         case (uword.op)
            gdhc_pkg::OP_LOAD: begin
               acc_in  = req_operation ? AW'(req_total_hours) : '0;
               y_in    = YW'(1);
               m_in    = 4'd1;
               d_in    = 5'd1;
               c4_in   = 2'd1;
               c100_in = 7'd1;
               c400_in = 9'd1;
               bad_in  = 1'b0;
            end
            gdhc_pkg::OP_SET_BAD:   bad_in = 1'b1;
            gdhc_pkg::OP_YEAR_ADD,
            gdhc_pkg::OP_YEAR_SUB: begin
               acc_in  = (uword.op == gdhc_pkg::OP_YEAR_ADD) ? acc_ff + year_hrs
                                                             : acc_ff - year_hrs;
               y_in    = y_ff + YW'(1);
               c4_in   = c4_ff + 2'd1;
               c100_in = (c100_ff == 7'd99)  ? 7'd0 : c100_ff + 7'd1;
               c400_in = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
            end
            gdhc_pkg::OP_MONTH_ADD: begin
               acc_in = acc_ff + month_hrs;
               m_in   = m_ff + 4'd1;
            end
            gdhc_pkg::OP_MONTH_SUB: begin
               acc_in = acc_ff - month_hrs;
               m_in   = m_ff + 4'd1;
            end
            gdhc_pkg::OP_DAY_SUB: begin
               acc_in = acc_ff - AW'(gdhc_pkg::HOURS_PER_DAY);
               d_in   = d_ff + 5'd1;
            end
            gdhc_pkg::OP_FWD_FIN:   acc_in = acc_ff + day_hrs;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (run && (uword.op == gdhc_pkg::OP_EMIT)) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= gdhc_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      y_ff    <= y_in;
      m_ff    <= m_in;
      d_ff    <= d_in;
      c4_ff   <= c4_in;
      c100_ff <= c100_in;
      c400_ff <= c400_in;
      bad_ff  <= bad_in;
      if (req_xfer) begin
         op_ff    <= req_operation;
         year_ff  <= req_year;
         month_ff <= req_month;
         day_ff   <= req_day;
         hour_ff  <= req_hour;
         total_ff <= req_total_hours;
      end
      if (run && (uword.op == gdhc_pkg::OP_EMIT)) begin
         valid_res_ff <= !bad_ff;
         if (op_ff) begin
            count_out_ff <= total_ff;
            year_out_ff  <= bad_ff ? '0 : y_ff[gdhc_pkg::YEAR_W-1:0];
            month_out_ff <= bad_ff ? '0 : m_ff;
            day_out_ff   <= bad_ff ? '0 : d_ff;
            hour_out_ff  <= bad_ff ? '0 : acc_ff[HW-1:0];
         end else begin
            count_out_ff <= bad_ff ? '0 : acc_ff[CW-1:0];
            year_out_ff  <= year_ff;
            month_out_ff <= month_ff;
            day_out_ff   <= day_ff;
            hour_out_ff  <= hour_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count_out = count_out_ff;
   assign rsp_year_out  = year_out_ff;
   assign rsp_month_out = month_out_ff;
   assign rsp_day_out   = day_out_ff;
   assign rsp_hour_out  = hour_out_ff;
   assign rsp_valid_res = valid_res_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // an accepted transfer starts the program at the dispatch step
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (pc_ff == gdhc_pkg::STEP_DISPATCH))
      else $error("sequencer did not start after request transfer");

   // a good reverse conversion leaves less than one day of hours
   a_rem: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == gdhc_pkg::STEP_EMIT && op_ff && !bad_ff)
         |-> (acc_ff < AW'(gdhc_pkg::HOURS_PER_DAY)))
      else $error("reverse remainder not below one day at emit");

   // results appear only from the emit step
   a_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(pc_ff) == gdhc_pkg::STEP_EMIT))
      else $error("result valid raised outside emit step");

   // month walk never leaves 1..12 once under way
   a_month: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == gdhc_pkg::STEP_EMIT) |-> (m_ff >= 4'd1 && m_ff <= gdhc_pkg::MONTHS))
      else $error("month counter out of range");

endmodule

FILE: tb/gdhc_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gdhc_tb_pkg: transfer types and result checking for the date / hour count unit
// Holds the request and result records and a scoreboard that works out the
// expected conversion for each accepted request and checks results in order.
// ----------------------------------------------------------------------------
package gdhc_tb_pkg;
   import gdhc_pkg::*;

   typedef enum logic {
      TO_COUNT = 1'b0,
      TO_DATE  = 1'b1
   } conversion_type;

   typedef struct packed {
      conversion_type       op;
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [HOUR_W-1:0]    hour;
      logic [COUNT_W-1:0]   total_hours;
   } date_request_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   count;
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [HOUR_W-1:0]    hour;
      logic                 valid_res;
   } date_result_type;

   class hour_count_scoreboard;
      int unsigned      last_year;
      date_result_type  awaited[$];
      int               failures;
      int               checked;
      int               out_of_range;

      function new(int unsigned max_year);
         last_year    = max_year;
         failures     = 0;
         checked      = 0;
         out_of_range = 0;
      endfunction

      function bit is_leap(int unsigned y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      // m in 1..12
      function int unsigned month_length(int unsigned y, int unsigned m);
         case (m)
            2:              return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
         endcase
      endfunction

      // days in years 1 .. y-1
      function int unsigned days_before_year(int unsigned y);
         int unsigned p;
         p = y - 1;
         return p * 365 + p / 4 - p / 100 + p / 400;
      endfunction

      function int unsigned hour_limit();
         return days_before_year(last_year + 1) * HOURS_PER_DAY;
      endfunction

      function date_result_type convert(date_request_type r);
         date_result_type res;
         int unsigned     days, t, y, m;
         res = '0;
         if (r.op == TO_COUNT) begin
            res.year  = r.year;
            res.month = r.month;
            res.day   = r.day;
            res.hour  = r.hour;
            if (r.year >= 1 && r.year <= last_year && r.month >= 1 && r.month <= MONTHS &&
                r.day >= 1 && r.day <= month_length(r.year, r.month) &&
                r.hour <= LAST_HOUR) begin
               days = days_before_year(r.year) + r.day - 1;
               for (m = 1; m < r.month; m++)
                  days += month_length(r.year, m);
               res.count     = COUNT_W'(days * HOURS_PER_DAY + r.hour);
               res.valid_res = 1'b1;
            end
         end else begin
            res.count = r.total_hours;
            t = r.total_hours;
            if (t < hour_limit()) begin
               y = 1;
               while (t >= (is_leap(y) ? 366 : 365) * HOURS_PER_DAY) begin
                  t -= (is_leap(y) ? 366 : 365) * HOURS_PER_DAY;
                  y++;
               end
               m = 1;
               while (m < MONTHS && t >= month_length(y, m) * HOURS_PER_DAY) begin
                  t -= month_length(y, m) * HOURS_PER_DAY;
                  m++;
               end
               res.year      = YEAR_W'(y);
               res.month     = MONTH_W'(m);
               res.day       = DAY_W'(t / HOURS_PER_DAY + 1);
               res.hour      = HOUR_W'(t % HOURS_PER_DAY);
               res.valid_res = 1'b1;
            end
         end
         return res;
      endfunction

      function void note_request(date_request_type r);
         awaited.push_back(convert(r));
      endfunction

      function void check_response(date_result_type got);
         date_result_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("[%0t] result with nothing awaited: count %0d date %0d-%0d-%0d %0dh",
                        $time, got.count, got.year, got.month, got.day, got.hour);
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (!want.valid_res)
            out_of_range++;
         if (got.count !== want.count || got.year !== want.year ||
             got.month !== want.month || got.day !== want.day ||
             got.hour !== want.hour || got.valid_res !== want.valid_res) begin
            failures++;
            if (failures <= 10) begin
               $display("[%0t] mismatch: want count %0d date %0d-%0d-%0d %0dh ok %0b",
                        $time, want.count, want.year, want.month, want.day, want.hour,
                        want.valid_res);
               $display("               got count %0d date %0d-%0d-%0d %0dh ok %0b",
                        got.count, got.year, got.month, got.day, got.hour, got.valid_res);
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

endpackage

FILE: tb/gregorian_date_hour_count_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_hour_count_unit_tb: self-checking bench for the converter
// Drives date-to-count and count-to-date requests (directed corners, then
// mostly well-formed random ones with some raw noise) under random sender
// bursts and receiver stalls, and checks every result against a scoreboard.
// ----------------------------------------------------------------------------
module gregorian_date_hour_count_unit_tb;
   import gdhc_pkg::*;
   import gdhc_tb_pkg::*;

   localparam int MAX_YEAR     = DEF_MAX_YEAR;
   localparam int RANDOM_ITEMS = 205;
   // slowest honest item: full year walk, longest sender gap, long receiver stall;
   // then a wide margin on top
   localparam int CYCLE_LIMIT  = (RANDOM_ITEMS + 30) * (MAX_YEAR + 3200) * 3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_operation;
   logic [YEAR_W-1:0]    req_year;
   logic [MONTH_W-1:0]   req_month;
   logic [DAY_W-1:0]     req_day;
   logic [HOUR_W-1:0]    req_hour;
   logic [COUNT_W-1:0]   req_total_hours;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [COUNT_W-1:0]   rsp_count_out;
   logic [YEAR_W-1:0]    rsp_year_out;
   logic [MONTH_W-1:0]   rsp_month_out;
   logic [DAY_W-1:0]     rsp_day_out;
   logic [HOUR_W-1:0]    rsp_hour_out;
   logic                 rsp_valid_res;

   hour_count_scoreboard sb;
   int                   burst_left;
   int                   n_to_count;
   int                   n_to_date;

   gregorian_date_hour_count_unit #(
      .MAX_YEAR(MAX_YEAR)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_year(req_year),
      .req_month(req_month),
      .req_day(req_day),
      .req_hour(req_hour),
      .req_total_hours(req_total_hours),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_count_out(rsp_count_out),
      .rsp_year_out(rsp_year_out),
      .rsp_month_out(rsp_month_out),
      .rsp_day_out(rsp_day_out),
      .rsp_hour_out(rsp_hour_out),
      .rsp_valid_res(rsp_valid_res)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a lost or stuck result ends the run here.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Result side. Outputs are sampled at the edge, so a transfer is seen with
   // the values the block held before it; stall is then driven for the next
   // cycle. The stall pattern switches between three moods for a random
   // stretch: never stalls, coin-toss stalls, and occasional long stalls.
   initial begin : result_side
      date_result_type got;
      int              mood, mood_left, stall_run;
      rsp_stall <= 1'b0;
      mood       = 0;
      mood_left  = 0;
      stall_run  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.count     = rsp_count_out;
            got.year      = rsp_year_out;
            got.month     = rsp_month_out;
            got.day       = rsp_day_out;
            got.hour      = rsp_hour_out;
            got.valid_res = rsp_valid_res;
            sb.check_response(got);
         end
         if (mood_left == 0) begin
            mood      = $urandom_range(0, 2);
            mood_left = $urandom_range(50, 2000);
         end
         mood_left--;
         case (mood)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               if (stall_run > 0) begin
                  stall_run--;
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
                  if ($urandom_range(0, 7) == 0)
                     stall_run = $urandom_range(5, 60);
               end
            end
         endcase
      end
   end

   // One request transfer. Valid is raised at an edge and held, payload steady,
   // until an edge sees it with stall low. At the end of a burst the sender
   // drops valid for a random gap; now and then the gap is long enough for the
   // block to fall idle. Valid is never lowered and raised in the same step.
   task automatic push_request(input date_request_type r);
      req_valid       <= 1'b1;
      req_operation   <= r.op;
      req_year        <= r.year;
      req_month       <= r.month;
      req_day         <= r.day;
      req_hour        <= r.hour;
      req_total_hours <= r.total_hours;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if (r.op == TO_COUNT)
         n_to_count++;
      else
         n_to_date++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(100, 3000)
                                             : $urandom_range(1, 20))
            @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 6);
      end
   endtask

   // Hold the sender off until every awaited result has been seen.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      burst_left = $urandom_range(1, 6);
   endtask

   // Unused fields carry random bits so that every input bit toggles.
   function automatic date_request_type noise_request();
      date_request_type r;
      r.op          = ($urandom_range(0, 1) == 1) ? TO_DATE : TO_COUNT;
      r.year        = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
      r.month       = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
      r.day         = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
      r.hour        = HOUR_W'($urandom_range(0, (1 << HOUR_W) - 1));
      r.total_hours = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
      return r;
   endfunction

   task automatic send_date(input int y, input int m, input int d, input int h);
      date_request_type r;
      r       = noise_request();
      r.op    = TO_COUNT;
      r.year  = YEAR_W'(y);
      r.month = MONTH_W'(m);
      r.day   = DAY_W'(d);
      r.hour  = HOUR_W'(h);
      push_request(r);
   endtask

   task automatic send_count(input int unsigned t);
      date_request_type r;
      r             = noise_request();
      r.op          = TO_DATE;
      r.total_hours = COUNT_W'(t);
      push_request(r);
   endtask

   // Random mix: mostly real dates and in-range counts, some counts within a day of
   // year boundaries or the upper limit, the rest raw bits (mostly rejected).
   function automatic date_request_type random_request();
      date_request_type r;
      int unsigned      pick, y, edge_hours;
      r    = noise_request();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         y       = $urandom_range(1, MAX_YEAR);
         r.op    = TO_COUNT;
         r.year  = YEAR_W'(y);
         r.month = MONTH_W'($urandom_range(1, MONTHS));
         r.day   = DAY_W'($urandom_range(1, sb.month_length(y, r.month)));
         r.hour  = HOUR_W'($urandom_range(0, LAST_HOUR));
      end else if (pick < 55) begin
         r.op = TO_COUNT;
      end else if (pick < 85) begin
         r.op          = TO_DATE;
         r.total_hours = COUNT_W'($urandom_range(0, sb.hour_limit() - 1));
      end else if (pick < 93) begin
         r.op = TO_DATE;
         if ($urandom_range(0, 3) == 0)
            edge_hours = sb.hour_limit();
         else
            edge_hours = sb.days_before_year($urandom_range(2, MAX_YEAR)) * HOURS_PER_DAY;
         r.total_hours = COUNT_W'(edge_hours + $urandom_range(0, 47) - 24);
      end else begin
         r.op = TO_DATE;
      end
      return r;
   endfunction

   initial begin : stimulus
      sb = new(MAX_YEAR);
      n_to_count = 0;
      n_to_date  = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= TO_COUNT;
      req_year        <= '0;
      req_month       <= '0;
      req_day         <= '0;
      req_hour        <= '0;
      req_total_hours <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 6);

      // date to count: first and last hour, leap rules, every way to be impossible
      send_date(1, 1, 1, 0);
      send_date(MAX_YEAR, 12, 31, 23);
      send_date(2000, 2, 29, 12);          // leap century
      send_date(1900, 2, 29, 0);           // century, not leap
      send_date(2024, 2, 29, 5);
      send_date(2023, 2, 29, 5);
      send_date(0, 6, 15, 10);             // year zero
      send_date(MAX_YEAR + 1, 1, 1, 0);    // past the last year
      send_date(4095, 15, 31, 31);         // all ones
      send_date(1999, 0, 1, 0);
      send_date(1999, 13, 1, 0);
      send_date(1999, 4, 0, 0);
      send_date(1999, 4, 31, 0);           // beyond a 30-day month
      send_date(1999, 1, 31, 0);
      send_date(1999, 7, 4, 24);           // hour past the day

      // count to date: origin, first year edge, leap day, top of range and beyond
      send_count(0);
      send_count(8759);
      send_count(8760);
      send_count((sb.days_before_year(2000) + 59) * HOURS_PER_DAY + 12);
      send_count((sb.days_before_year(1900) + 59) * HOURS_PER_DAY);
      send_count(sb.days_before_year(2001) * HOURS_PER_DAY - 1);
      send_count(sb.hour_limit() - 1);
      send_count(sb.hour_limit());
      send_count((1 << COUNT_W) - 1);

      wait_for_drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         push_request(random_request());
         if (i == RANDOM_ITEMS / 2)
            wait_for_drain();
      end

      // all requests are in: wait out the results, then a full year walk more
      // in case something extra comes out
      wait_for_drain();
      repeat (MAX_YEAR + 100) @(posedge clock);

      $display("Sent %0d date-to-count and %0d count-to-date transfers under random stalls;",
               n_to_count, n_to_date);
      $display("checked %0d results, %0d of them flagged out of range, %0d failures",
               sb.checked, sb.out_of_range, sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/gdhc_pkg.sv
design/gdhc_urom.sv
design/gregorian_date_hour_count_unit.sv
tb/gdhc_tb_pkg.sv
tb/gregorian_date_hour_count_unit_tb.sv
